>>> rtl/core/ffb_cq_pkg.sv
// Shared constants, payload types and helper functions of the force-feedback coalescing queue.
package ffb_cq_pkg;

    localparam int NUM_DEVICES = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int EXT_ENTRIES = 16;
    localparam int SLOTS       = 4;

    localparam int DV_W  = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int QA_W  = $clog2(NUM_DEVICES * QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_N = NUM_DEVICES * EXT_ENTRIES;
    localparam int EA_W  = (EXT_N > 1) ? $clog2(EXT_N) : 1;
    localparam int EC_W  = $clog2(EXT_ENTRIES + 1);
    localparam int SLOT_N = NUM_DEVICES * SLOTS;
    localparam int SI_W  = $clog2(SLOT_N);

    localparam logic [7:0] HEAD_EXT   = 8'hF8;
    localparam logic [7:0] SLOT_FIELD = 8'hF0;
    localparam logic [7:0] CMD_FIELD  = 8'h0F;

    // slot command nibble
    localparam logic [3:0] CMD_LOAD_PARAMS = 4'h0;
    localparam logic [3:0] CMD_DL_PLAY     = 4'h1;
    localparam logic [3:0] CMD_START       = 4'h2;
    localparam logic [3:0] CMD_HALT        = 4'h3;
    localparam logic [3:0] CMD_REFRESH     = 4'hC;

    // extended codes that are dropped on arrival
    localparam logic [7:0] EXT_SKIP_A = 8'h01;
    localparam logic [7:0] EXT_SKIP_B = 8'h09;
    localparam logic [7:0] EXT_SKIP_C = 8'h0A;
    localparam logic [7:0] EXT_SKIP_D = 8'h10;
    localparam logic [7:0] EXT_SKIP_E = 8'h11;

    localparam logic [1:0] MODE_ABSORB = 2'd0;
    localparam logic [1:0] MODE_FETCH  = 2'd1;
    localparam logic [1:0] MODE_ACK    = 2'd2;

    localparam logic [1:0] Q_PUSH   = 2'd0;
    localparam logic [1:0] Q_REMOVE = 2'd1;
    localparam logic [1:0] Q_PEEK   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  device;
        logic [7:0]  report_head;
        logic [47:0] report_payload;
    } in_t;

    typedef struct packed {
        logic        report_present;
        logic [7:0]  out_head;
        logic [47:0] out_payload;
        logic        queue_overflow;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [2:0]  dev;
        logic [15:0] key;
        logic        dedup;
    } q_req_t;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic        ovf;
        logic [15:0] entry;
    } q_resp_t;

    function automatic logic same_entry(input logic [15:0] a, input logic [15:0] b);
        return (a[7:0] == b[7:0]) && ((a[7:0] != HEAD_EXT) || (a[15:8] == b[15:8]));
    endfunction

    function automatic logic is_slot_cmd(input logic [3:0] c);
        return (c == CMD_LOAD_PARAMS) || (c == CMD_DL_PLAY) || (c == CMD_START) ||
               (c == CMD_HALT) || (c == CMD_REFRESH);
    endfunction

    function automatic logic is_ext_skipped(input logic [7:0] c);
        return (c == EXT_SKIP_A) || (c == EXT_SKIP_B) || (c == EXT_SKIP_C) ||
               (c == EXT_SKIP_D) || (c == EXT_SKIP_E);
    endfunction

endpackage

>>> rtl/core/ffb_cq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ffb_cq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ffb_cq_queue.sv
// Pending-command queue engine: push with optional dedup, remove with shift-down, head peek.
module ffb_cq_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffb_cq_pkg::q_req_t  req,
    output ffb_cq_pkg::q_resp_t resp
);

    localparam logic [2:0] Q_IDLE  = 3'd0;
    localparam logic [2:0] Q_SCAN  = 3'd1;
    localparam logic [2:0] Q_CHK   = 3'd2;
    localparam logic [2:0] Q_SH_RD = 3'd3;
    localparam logic [2:0] Q_SH_WR = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [2:0]                     dev_reg, dev_next;
    logic [15:0]                    key_reg, key_next;
    logic                           dedup_reg, dedup_next;
    logic [ffb_cq_pkg::QC_W-1:0]    idx_reg, idx_next;
    logic [ffb_cq_pkg::QC_W-1:0]    cnt_reg [ffb_cq_pkg::NUM_DEVICES];
    logic [ffb_cq_pkg::QC_W-1:0]    cnt_next [ffb_cq_pkg::NUM_DEVICES];
    logic                           done_reg, done_next;
    logic                           ovf_reg, ovf_next;
    logic [15:0]                    entry_reg, entry_next;

    logic                           ram_we;
    logic [ffb_cq_pkg::QA_W-1:0]    ram_waddr, ram_raddr, base;
    logic [15:0]                    ram_wdata, ram_rdata;
    logic [ffb_cq_pkg::QC_W-1:0]    cnt;
    logic [ffb_cq_pkg::DV_W-1:0]    dv;

    ffb_cq_ram #(.WIDTH(16), .DEPTH(ffb_cq_pkg::NUM_DEVICES * ffb_cq_pkg::QUEUE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dv   = ffb_cq_pkg::DV_W'(dev_reg);
    assign cnt  = cnt_reg[dv];
    assign base = ffb_cq_pkg::QA_W'(dev_reg) * ffb_cq_pkg::QA_W'(ffb_cq_pkg::QUEUE_DEPTH);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        dev_next   = dev_reg;
        key_next   = key_reg;
        dedup_next = dedup_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = 1'b0;
        entry_next = entry_reg;
        ram_we     = 1'b0;
        ram_waddr  = base + ffb_cq_pkg::QA_W'(idx_reg);
        ram_wdata  = ram_rdata;
        ram_raddr  = base + ffb_cq_pkg::QA_W'(idx_reg);
        unique case (state_reg)
            Q_IDLE: begin
                if (req.valid) begin
                    op_next    = req.op;
                    dev_next   = req.dev;
                    key_next   = req.key;
                    dedup_next = req.dedup;
                    idx_next   = '0;
                    state_next = Q_SCAN;
                end
            end
            Q_SCAN: begin
                unique case (op_reg)
                    ffb_cq_pkg::Q_PEEK: begin
                        if (cnt == '0) begin
                            entry_next = '0;
                            done_next  = 1'b1;
                            state_next = Q_IDLE;
                        end else begin
                            state_next = Q_CHK;
                        end
                    end
                    ffb_cq_pkg::Q_PUSH: begin
                        if (!dedup_reg || idx_reg == cnt) begin
                            // append at the tail, or drop when full
                            if (cnt < ffb_cq_pkg::QC_W'(ffb_cq_pkg::QUEUE_DEPTH)) begin
                                ram_we       = 1'b1;
                                ram_waddr    = base + ffb_cq_pkg::QA_W'(cnt);
                                ram_wdata    = key_reg;
                                cnt_next[dv] = cnt + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                            done_next  = 1'b1;
                            state_next = Q_IDLE;
                        end else begin
                            state_next = Q_CHK;
                        end
                    end
                    default: begin
                        if (idx_reg == cnt) begin
                            done_next  = 1'b1;
                            state_next = Q_IDLE;
                        end else begin
                            state_next = Q_CHK;
                        end
                    end
                endcase
            end
            Q_CHK: begin
                if (op_reg == ffb_cq_pkg::Q_PEEK) begin
                    entry_next = ram_rdata;
                    done_next  = 1'b1;
                    state_next = Q_IDLE;
                end else if (ffb_cq_pkg::same_entry(ram_rdata, key_reg)) begin
                    if (op_reg == ffb_cq_pkg::Q_PUSH) begin
                        done_next  = 1'b1;
                        state_next = Q_IDLE;
                    end else begin
                        state_next = Q_SH_RD;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = Q_SCAN;
                end
            end
            Q_SH_RD: begin
                // move entry idx+1 down to idx until the tail
                ram_raddr = base + ffb_cq_pkg::QA_W'(idx_reg + 1'b1);
                if ((idx_reg + 1'b1) < cnt) begin
                    state_next = Q_SH_WR;
                end else begin
                    cnt_next[dv] = cnt - 1'b1;
                    done_next    = 1'b1;
                    state_next   = Q_IDLE;
                end
            end
            Q_SH_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = Q_SH_RD;
            end
            default: begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < ffb_cq_pkg::NUM_DEVICES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
        op_reg    <= op_next;
        dev_reg   <= dev_next;
        key_reg   <= key_next;
        dedup_reg <= dedup_next;
        idx_reg   <= idx_next;
        entry_reg <= entry_next;
    end

    assign resp.idle  = (state_reg == Q_IDLE);
    assign resp.done  = done_reg;
    assign resp.ovf   = ovf_reg;
    assign resp.entry = entry_reg;

endmodule

>>> rtl/core/ffb_command_coalescing_queue.sv
// Top level of the force-feedback command coalescing queue: sequencer, slot state, ext table.
//
// One transaction is one step: absorb an incoming report (mode 0), fetch the next outgoing
// report (mode 1) or acknowledge the last one sent (mode 2), for the device it names; each
// step yields exactly one result transaction. Steps run one at a time. The pending queue
// and the extended-command table (bytes plus pending flag per entry) live in RAMs with a
// registered read, scanned one entry at a time. A step is shortest when it touches neither
// queue nor table (mode 3, a multi-slot stop); each slot visited by a slot command, each
// queue operation and each entry it compares or shifts, and each table entry read make it
// longer. A stop-all absorb with a full queue is the longest step. Reset takes effect at
// once: queue fill counts and table valid counts are cleared in flops, so no clearing pass
// runs. A finished result sits in an output register; the next transaction is taken once
// that register is loaded.
module ffb_command_coalescing_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffb_cq_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ffb_cq_pkg::out_t  m_data
);

    localparam logic [3:0] T_IDLE    = 4'd0;
    localparam logic [3:0] T_DECODE  = 4'd1;
    localparam logic [3:0] T_SLOT    = 4'd2;
    localparam logic [3:0] T_WAITQ   = 4'd3;
    localparam logic [3:0] T_EXT_RD  = 4'd4;
    localparam logic [3:0] T_EXT_CHK = 4'd5;
    localparam logic [3:0] T_FQ_WAIT = 4'd6;
    localparam logic [3:0] T_OUT     = 4'd7;

    logic [3:0]                  state_reg, state_next;
    ffb_cq_pkg::in_t             item_reg, item_next;
    logic [1:0]                  j_reg, j_next;
    logic [ffb_cq_pkg::EC_W-1:0] eidx_reg, eidx_next;
    logic [7:0]                  code_reg, code_next;
    logic                        ovf_reg, ovf_next;
    logic                        present_reg, present_next;
    logic                        loop_reg, loop_next;
    ffb_cq_pkg::out_t            out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    // per-slot state, flat index device * SLOTS + slot
    logic        slot_active_reg  [ffb_cq_pkg::SLOT_N];
    logic        slot_active_next [ffb_cq_pkg::SLOT_N];
    logic        slot_pending_reg  [ffb_cq_pkg::SLOT_N];
    logic        slot_pending_next [ffb_cq_pkg::SLOT_N];
    logic [47:0] slot_params_reg  [ffb_cq_pkg::SLOT_N];
    logic [47:0] slot_params_next [ffb_cq_pkg::SLOT_N];

    // ext table: bytes and pending flag (bit 48) sit in RAM, filled from index 0 upward
    logic [ffb_cq_pkg::EC_W-1:0] ext_cnt_reg  [ffb_cq_pkg::NUM_DEVICES];
    logic [ffb_cq_pkg::EC_W-1:0] ext_cnt_next [ffb_cq_pkg::NUM_DEVICES];

    logic [55:0] last_reg  [ffb_cq_pkg::NUM_DEVICES];
    logic [55:0] last_next [ffb_cq_pkg::NUM_DEVICES];

    ffb_cq_pkg::q_req_t          q_req;
    ffb_cq_pkg::q_resp_t         q_resp;

    logic                        ext_we;
    logic [ffb_cq_pkg::EA_W-1:0] ext_addr, ext_base;
    logic [48:0]                 ext_wdata, ext_rdata;

    logic [ffb_cq_pkg::DV_W-1:0] dv;
    logic [ffb_cq_pkg::SI_W-1:0] slot_base, sidx, fsidx;
    logic [7:0]                  head, lh;
    logic [3:0]                  cmd;
    logic                        stop_all, slot_bit, dev_ok;
    logic [3:0]                  slot_onehot, pend_mask;
    logic [2:0]                  pend_cnt;
    logic [15:0]                 slot_key, ext_key;
    logic [1:0]                  fj;
    logic [47:0]                 pay;

    ffb_cq_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .resp    (q_resp)
    );

    ffb_cq_ram #(.WIDTH(49), .DEPTH(ffb_cq_pkg::EXT_N)) u_ext_ram (
        .aclk  (aclk),
        .we    (ext_we),
        .waddr (ext_addr),
        .wdata (ext_wdata),
        .raddr (ext_addr),
        .rdata (ext_rdata)
    );

    assign dv        = ffb_cq_pkg::DV_W'(item_reg.device);
    assign dev_ok    = (32'(item_reg.device) < ffb_cq_pkg::NUM_DEVICES);
    assign slot_base = ffb_cq_pkg::SI_W'(item_reg.device) * ffb_cq_pkg::SI_W'(ffb_cq_pkg::SLOTS);
    assign sidx      = slot_base + ffb_cq_pkg::SI_W'(j_reg);
    assign ext_base  = ffb_cq_pkg::EA_W'(item_reg.device)
                     * ffb_cq_pkg::EA_W'(ffb_cq_pkg::EXT_ENTRIES);
    assign ext_addr  = ext_base + ffb_cq_pkg::EA_W'(eidx_reg);
    assign head      = item_reg.report_head;
    assign pay       = item_reg.report_payload;
    assign cmd       = head[3:0];
    assign lh        = last_reg[dv][7:0];
    assign stop_all  = (cmd == ffb_cq_pkg::CMD_HALT) &&
                       ((head & ffb_cq_pkg::SLOT_FIELD) == ffb_cq_pkg::SLOT_FIELD);
    assign slot_onehot = 4'b0001 << j_reg;
    assign slot_key  = {8'h00, slot_onehot, 4'h0};
    assign ext_key   = {code_reg, ffb_cq_pkg::HEAD_EXT};
    assign slot_bit  = (item_reg.mode == ffb_cq_pkg::MODE_ACK) ? lh[4 + j_reg] :
                       (stop_all || head[4 + j_reg]);

    // stopped slots still owing a report, for the multi-slot stop
    always_comb begin
        pend_cnt = '0;
        for (int k = 0; k < ffb_cq_pkg::SLOTS; k++) begin
            pend_mask[k] = slot_pending_reg[slot_base + ffb_cq_pkg::SI_W'(k)] &&
                           !slot_active_reg[slot_base + ffb_cq_pkg::SI_W'(k)];
            pend_cnt     = pend_cnt + 3'(pend_mask[k]);
        end
    end

    // slot addressed by a queued slot entry: lowest set bit, slot 3 otherwise
    always_comb begin
        if (q_resp.entry[4]) begin
            fj = 2'd0;
        end else if (q_resp.entry[5]) begin
            fj = 2'd1;
        end else if (q_resp.entry[6]) begin
            fj = 2'd2;
        end else begin
            fj = 2'd3;
        end
    end
    assign fsidx = slot_base + ffb_cq_pkg::SI_W'(fj);

    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        j_next            = j_reg;
        eidx_next         = eidx_reg;
        code_next         = code_reg;
        ovf_next          = ovf_reg;
        present_next      = present_reg;
        loop_next         = loop_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        slot_active_next  = slot_active_reg;
        slot_pending_next = slot_pending_reg;
        slot_params_next  = slot_params_reg;
        ext_cnt_next      = ext_cnt_reg;
        last_next         = last_reg;
        q_req             = '0;
        q_req.dev         = item_reg.device;
        ext_we            = 1'b0;
        ext_wdata         = {1'b1, pay};

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    ovf_next     = 1'b0;
                    present_next = 1'b0;
                    loop_next    = 1'b0;
                    state_next   = T_DECODE;
                end
            end
            T_DECODE: begin
                state_next = T_OUT;
                if (dev_ok) begin
                    unique case (item_reg.mode)
                        ffb_cq_pkg::MODE_ABSORB: begin
                            if (head != ffb_cq_pkg::HEAD_EXT) begin
                                if (stop_all || ffb_cq_pkg::is_slot_cmd(cmd)) begin
                                    j_next     = '0;
                                    state_next = T_SLOT;
                                end else begin
                                    // other commands queue as-is, no dedup
                                    q_req.valid = 1'b1;
                                    q_req.op    = ffb_cq_pkg::Q_PUSH;
                                    q_req.key   = {8'h00, head};
                                    q_req.dedup = 1'b0;
                                    loop_next   = 1'b0;
                                    state_next  = T_WAITQ;
                                end
                            end else if (!ffb_cq_pkg::is_ext_skipped(pay[7:0])) begin
                                code_next  = pay[7:0];
                                eidx_next  = '0;
                                state_next = T_EXT_RD;
                            end
                        end
                        ffb_cq_pkg::MODE_FETCH: begin
                            if (pend_cnt > 3'd1) begin
                                last_next[dv] = {48'h0, pend_mask, ffb_cq_pkg::CMD_HALT};
                                for (int k = 0; k < ffb_cq_pkg::SLOTS; k++) begin
                                    if (pend_mask[k]) begin
                                        slot_pending_next[slot_base + ffb_cq_pkg::SI_W'(k)] = 1'b0;
                                    end
                                end
                                present_next = 1'b1;
                            end else begin
                                q_req.valid = 1'b1;
                                q_req.op    = ffb_cq_pkg::Q_PEEK;
                                state_next  = T_FQ_WAIT;
                            end
                        end
                        ffb_cq_pkg::MODE_ACK: begin
                            if (lh != ffb_cq_pkg::HEAD_EXT) begin
                                if (!ffb_cq_pkg::is_slot_cmd(lh[3:0])) begin
                                    q_req.valid = 1'b1;
                                    q_req.op    = ffb_cq_pkg::Q_REMOVE;
                                    q_req.key   = {8'h00, lh};
                                    loop_next   = 1'b0;
                                    state_next  = T_WAITQ;
                                end else begin
                                    j_next     = '0;
                                    state_next = T_SLOT;
                                end
                            end else begin
                                code_next  = last_reg[dv][15:8];
                                eidx_next  = '0;
                                state_next = T_EXT_RD;
                            end
                        end
                        default: begin
                            state_next = T_OUT;
                        end
                    endcase
                end
            end
            T_SLOT: begin
                if (item_reg.mode == ffb_cq_pkg::MODE_ACK) begin
                    // drop the slot's entry unless it changed again since sent
                    if (slot_bit && !slot_pending_reg[sidx]) begin
                        q_req.valid = 1'b1;
                        q_req.op    = ffb_cq_pkg::Q_REMOVE;
                        q_req.key   = slot_key;
                    end
                end else if (stop_all) begin
                    slot_pending_next[sidx] = 1'b1;
                    slot_active_next[sidx]  = 1'b0;
                    slot_params_next[sidx]  = '0;
                    q_req.valid = 1'b1;
                end else if (slot_bit) begin
                    case (cmd) inside
                        ffb_cq_pkg::CMD_LOAD_PARAMS: begin
                            slot_params_next[sidx] = pay;
                        end
                        ffb_cq_pkg::CMD_DL_PLAY, ffb_cq_pkg::CMD_REFRESH: begin
                            if (!(slot_active_reg[sidx] && slot_params_reg[sidx] == pay)) begin
                                slot_active_next[sidx]  = 1'b1;
                                slot_params_next[sidx]  = pay;
                                slot_pending_next[sidx] = 1'b1;
                                q_req.valid = 1'b1;
                            end
                        end
                        ffb_cq_pkg::CMD_START: begin
                            if (!slot_active_reg[sidx]) begin
                                slot_active_next[sidx]  = 1'b1;
                                slot_pending_next[sidx] = 1'b1;
                                q_req.valid = 1'b1;
                            end
                        end
                        default: begin
                            if (slot_active_reg[sidx]) begin
                                slot_active_next[sidx]  = 1'b0;
                                slot_params_next[sidx]  = '0;
                                slot_pending_next[sidx] = 1'b1;
                                q_req.valid = 1'b1;
                            end
                        end
                    endcase
                end
                if (item_reg.mode != ffb_cq_pkg::MODE_ACK) begin
                    q_req.op    = ffb_cq_pkg::Q_PUSH;
                    q_req.key   = slot_key;
                    q_req.dedup = 1'b1;
                end
                if (q_req.valid) begin
                    loop_next  = 1'b1;
                    state_next = T_WAITQ;
                end else if (j_reg == 2'd3) begin
                    state_next = T_OUT;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            T_WAITQ: begin
                if (q_resp.done) begin
                    ovf_next = ovf_reg | q_resp.ovf;
                    if (loop_reg && j_reg != 2'd3) begin
                        j_next     = j_reg + 1'b1;
                        state_next = T_SLOT;
                    end else begin
                        state_next = T_OUT;
                    end
                end
            end
            T_EXT_RD: begin
                if (eidx_reg == ext_cnt_reg[dv]) begin
                    // searched every filled entry without a match
                    state_next = T_OUT;
                    if (item_reg.mode == ffb_cq_pkg::MODE_ABSORB) begin
                        if (ext_cnt_reg[dv] < ffb_cq_pkg::EC_W'(ffb_cq_pkg::EXT_ENTRIES)) begin
                            ext_we           = 1'b1;
                            ext_wdata        = {1'b1, pay};
                            ext_cnt_next[dv] = ext_cnt_reg[dv] + 1'b1;
                            q_req.valid = 1'b1;
                            q_req.op    = ffb_cq_pkg::Q_PUSH;
                            q_req.key   = ext_key;
                            q_req.dedup = 1'b1;
                            loop_next   = 1'b0;
                            state_next  = T_WAITQ;
                        end
                    end else if (item_reg.mode == ffb_cq_pkg::MODE_FETCH) begin
                        last_next[dv] = '0;
                    end
                end else begin
                    state_next = T_EXT_CHK;
                end
            end
            T_EXT_CHK: begin
                if (ext_rdata[7:0] == code_reg) begin
                    state_next = T_OUT;
                    unique case (item_reg.mode)
                        ffb_cq_pkg::MODE_ABSORB: begin
                            if (ext_rdata[47:0] != pay) begin
                                ext_we      = 1'b1;
                                ext_wdata   = {1'b1, pay};
                                q_req.valid = 1'b1;
                                q_req.op    = ffb_cq_pkg::Q_PUSH;
                                q_req.key   = ext_key;
                                q_req.dedup = 1'b1;
                                loop_next   = 1'b0;
                                state_next  = T_WAITQ;
                            end
                        end
                        ffb_cq_pkg::MODE_ACK: begin
                            if (!ext_rdata[48]) begin
                                q_req.valid = 1'b1;
                                q_req.op    = ffb_cq_pkg::Q_REMOVE;
                                q_req.key   = ext_key;
                                loop_next   = 1'b0;
                                state_next  = T_WAITQ;
                            end
                        end
                        default: begin
                            // sent: clear the entry's pending flag in place
                            last_next[dv] = {ext_rdata[47:0], ffb_cq_pkg::HEAD_EXT};
                            ext_we        = 1'b1;
                            ext_wdata     = {1'b0, ext_rdata[47:0]};
                            present_next  = 1'b1;
                        end
                    endcase
                end else begin
                    eidx_next  = eidx_reg + 1'b1;
                    state_next = T_EXT_RD;
                end
            end
            T_FQ_WAIT: begin
                if (q_resp.done) begin
                    state_next = T_OUT;
                    if (q_resp.entry[7:0] == 8'h00) begin
                        // queue empty: nothing to send, last report kept
                    end else if (q_resp.entry[7:0] != ffb_cq_pkg::HEAD_EXT) begin
                        present_next = 1'b1;
                        if ((q_resp.entry[7:0] & ffb_cq_pkg::CMD_FIELD) != 8'h00) begin
                            last_next[dv] = {48'h0, q_resp.entry[7:0]};
                        end else begin
                            if (slot_active_reg[fsidx]) begin
                                last_next[dv] = {slot_params_reg[fsidx], q_resp.entry[7:4],
                                                 ffb_cq_pkg::CMD_DL_PLAY};
                            end else begin
                                last_next[dv] = {48'h0, q_resp.entry[7:4], ffb_cq_pkg::CMD_HALT};
                            end
                            slot_pending_next[fsidx] = 1'b0;
                        end
                    end else begin
                        code_next  = q_resp.entry[15:8];
                        eidx_next  = '0;
                        state_next = T_EXT_RD;
                    end
                end
            end
            T_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.report_present = present_reg;
                    out_next.out_head       = present_reg ? last_reg[dv][7:0] : 8'h00;
                    out_next.out_payload    = present_reg ? last_reg[dv][55:8] : 48'h0;
                    out_next.queue_overflow = ovf_reg;
                    out_valid_next          = 1'b1;
                    state_next              = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ffb_cq_pkg::SLOT_N; i++) begin
                slot_active_reg[i]  <= 1'b0;
                slot_pending_reg[i] <= 1'b0;
                slot_params_reg[i]  <= '0;
            end
            for (int i = 0; i < ffb_cq_pkg::NUM_DEVICES; i++) begin
                ext_cnt_reg[i] <= '0;
                last_reg[i]    <= '0;
            end
        end else begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            slot_active_reg  <= slot_active_next;
            slot_pending_reg <= slot_pending_next;
            slot_params_reg  <= slot_params_next;
            ext_cnt_reg      <= ext_cnt_next;
            last_reg         <= last_next;
        end
        item_reg    <= item_next;
        j_reg       <= j_next;
        eidx_reg    <= eidx_next;
        code_reg    <= code_next;
        ovf_reg     <= ovf_next;
        present_reg <= present_next;
        loop_reg    <= loop_next;
        out_reg     <= out_next;
    end

    assign s_ready = (state_reg == T_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // queue engine only gets a request when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_req.valid |-> q_resp.idle)
        else $error("queue request while queue engine busy");

    // a result with no report carries an all-zero report
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.report_present) |->
        (m_data.out_head == 8'h00 && m_data.out_payload == 48'h0))
        else $error("report bytes without report_present");

    // overflow only comes from an absorb, which never produces a report
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.queue_overflow) |-> !m_data.report_present)
        else $error("overflow flagged on a fetch result");

    // a transaction is taken only with the sequencer back at rest
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == T_DECODE))
        else $error("accepted transaction not decoded");

endmodule

>>> tb/sv/tb_ffb_command_coalescing_queue.sv
// Testbench for the force-feedback command coalescing queue: directed and random steps checked against a predictor.
module tb_ffb_command_coalescing_queue;

    localparam int NDEV = ffb_cq_pkg::NUM_DEVICES;
    localparam int QD   = ffb_cq_pkg::QUEUE_DEPTH;
    localparam int EXTN = ffb_cq_pkg::EXT_ENTRIES;
    localparam int NSL  = ffb_cq_pkg::SLOTS;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Predictor of the coalescing queue: per-device slot state, extended table,
    // pending queue and the last report sent.
    class ffb_scoreboard;
        bit          sl_act [NDEV][NSL];
        bit          sl_pend[NDEV][NSL];
        bit [47:0]   sl_par [NDEV][NSL];
        bit          ex_val [NDEV][EXTN];
        bit          ex_pend[NDEV][EXTN];
        bit [47:0]   ex_dat [NDEV][EXTN];
        bit [15:0]   pq     [NDEV][QD];
        bit [55:0]   sent   [NDEV];
        ffb_cq_pkg::out_t expected_q[$];
        int          errors;
        int          checked;
        int          reports_seen;
        int          overflows_seen;

        function bit key_match(bit [15:0] a, bit [15:0] b);
            if (a[7:0] != b[7:0]) return 0;
            return (a[7:0] != ffb_cq_pkg::HEAD_EXT) || (a[15:8] == b[15:8]);
        endfunction

        function bit slot_cmd(bit [3:0] c);
            return c == ffb_cq_pkg::CMD_LOAD_PARAMS || c == ffb_cq_pkg::CMD_DL_PLAY ||
                   c == ffb_cq_pkg::CMD_START || c == ffb_cq_pkg::CMD_HALT ||
                   c == ffb_cq_pkg::CMD_REFRESH;
        endfunction

        // returns 1 when dropped for lack of room
        function bit q_push(int d, bit [15:0] k, bit dedup);
            for (int i = 0; i < QD; i++) begin
                if (pq[d][i][7:0] == 0) begin
                    pq[d][i] = k;
                    return 0;
                end
                if (dedup && key_match(pq[d][i], k)) return 0;
            end
            return 1;
        endfunction

        function void q_remove(int d, bit [15:0] k);
            for (int i = 0; i < QD; i++) begin
                if (pq[d][i][7:0] == 0) return;
                if (key_match(pq[d][i], k)) begin
                    for (int m = i; m < QD - 1; m++) pq[d][m] = pq[d][m+1];
                    pq[d][QD-1] = 0;
                    return;
                end
            end
        endfunction

        function bit absorb(int d, bit [7:0] h, bit [47:0] p);
            bit ovf;
            bit [3:0] c;
            bit [7:0] code;
            bit [15:0] k;
            ovf = 0;
            c = h[3:0];
            if (h != ffb_cq_pkg::HEAD_EXT) begin
                if (c == ffb_cq_pkg::CMD_HALT && h[7:4] == 4'hF) begin
                    for (int j = 0; j < NSL; j++) begin
                        sl_pend[d][j] = 1;
                        sl_act[d][j] = 0;
                        sl_par[d][j] = 0;
                        ovf |= q_push(d, 16'h10 << j, 1);
                    end
                    return ovf;
                end
                if (!slot_cmd(c)) return q_push(d, {8'h00, h}, 0);
                for (int j = 0; j < NSL; j++) begin
                    if (!h[4+j]) continue;
                    if (c == ffb_cq_pkg::CMD_LOAD_PARAMS) begin
                        sl_par[d][j] = p;
                        continue;
                    end else if (c == ffb_cq_pkg::CMD_DL_PLAY || c == ffb_cq_pkg::CMD_REFRESH) begin
                        if (sl_act[d][j] && sl_par[d][j] == p) continue;
                        sl_act[d][j] = 1;
                        sl_par[d][j] = p;
                    end else if (c == ffb_cq_pkg::CMD_START) begin
                        if (sl_act[d][j]) continue;
                        sl_act[d][j] = 1;
                    end else begin
                        if (!sl_act[d][j]) continue;
                        sl_act[d][j] = 0;
                        sl_par[d][j] = 0;
                    end
                    sl_pend[d][j] = 1;
                    ovf |= q_push(d, 16'h10 << j, 1);
                end
                return ovf;
            end
            code = p[7:0];
            k = {code, ffb_cq_pkg::HEAD_EXT};
            if (ffb_cq_pkg::is_ext_skipped(code)) return 0;
            for (int i = 0; i < EXTN; i++) begin
                if (!ex_val[d][i]) begin
                    ex_val[d][i] = 1;
                    ex_dat[d][i] = p;
                    ex_pend[d][i] = 1;
                    return q_push(d, k, 1);
                end
                if (ex_dat[d][i][7:0] == code) begin
                    if (ex_dat[d][i] != p) begin
                        ex_dat[d][i] = p;
                        ex_pend[d][i] = 1;
                        return q_push(d, k, 1);
                    end
                    return 0;
                end
            end
            return 0;
        endfunction

        function bit fetch(int d);
            bit [7:0] mask, c;
            int cnt, j;
            bit [15:0] e;
            mask = 0;
            cnt = 0;
            for (j = 0; j < NSL; j++)
                if (sl_pend[d][j] && !sl_act[d][j]) begin
                    mask |= 8'h10 << j;
                    cnt++;
                end
            if (cnt > 1) begin
                sent[d] = {48'h0, mask | 8'h03};
                for (j = 0; j < NSL; j++) if (mask[4+j]) sl_pend[d][j] = 0;
                return 1;
            end
            e = pq[d][0];
            if (e[7:0] == 0) return 0;
            sent[d] = 0;
            if (e[7:0] != ffb_cq_pkg::HEAD_EXT) begin
                c = e[7:0];
                if (c[3:0] != 0) begin
                    sent[d] = {48'h0, c};
                    return 1;
                end
                for (j = 0; j < NSL - 1; j++) if (c[4+j]) break;
                if (sl_act[d][j]) sent[d] = {sl_par[d][j], c | 8'h01};
                else sent[d] = {48'h0, c | 8'h03};
                sl_pend[d][j] = 0;
                return 1;
            end
            for (int i = 0; i < EXTN; i++)
                if (ex_val[d][i] && ex_dat[d][i][7:0] == e[15:8]) begin
                    sent[d] = {ex_dat[d][i], ffb_cq_pkg::HEAD_EXT};
                    ex_pend[d][i] = 0;
                    return 1;
                end
            return 0;
        endfunction

        function void acknowledge(int d);
            bit [7:0] h, code;
            h = sent[d][7:0];
            code = sent[d][15:8];
            if (h != ffb_cq_pkg::HEAD_EXT) begin
                if (!slot_cmd(h[3:0])) begin
                    q_remove(d, {8'h00, h});
                    return;
                end
                for (int j = 0; j < NSL; j++)
                    if (h[4+j] && !sl_pend[d][j]) q_remove(d, 16'h10 << j);
                return;
            end
            for (int i = 0; i < EXTN; i++)
                if (ex_val[d][i] && ex_dat[d][i][7:0] == code) begin
                    if (!ex_pend[d][i]) q_remove(d, {code, ffb_cq_pkg::HEAD_EXT});
                    return;
                end
        endfunction

        // Note an accepted step and queue its expected result.
        function void note_step(ffb_cq_pkg::in_t t);
            ffb_cq_pkg::out_t r;
            int d;
            r = '0;
            d = t.device;
            if (t.mode == ffb_cq_pkg::MODE_ABSORB)
                r.queue_overflow = absorb(d, t.report_head, t.report_payload);
            else if (t.mode == ffb_cq_pkg::MODE_FETCH) begin
                if (fetch(d)) begin
                    r.report_present = 1;
                    r.out_head = sent[d][7:0];
                    r.out_payload = sent[d][55:8];
                end
            end else if (t.mode == ffb_cq_pkg::MODE_ACK) acknowledge(d);
            expected_q.push_back(r);
        endfunction

        function void check_result(ffb_cq_pkg::out_t got);
            ffb_cq_pkg::out_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (got.report_present) reports_seen++;
            if (got.queue_overflow) overflows_seen++;
            if (got.report_present !== exp_r.report_present)
                $display("%0t: report_present exp %b got %b", $time,
                         exp_r.report_present, got.report_present);
            if (got.out_head !== exp_r.out_head)
                $display("%0t: out_head exp %h got %h", $time, exp_r.out_head, got.out_head);
            if (got.out_payload !== exp_r.out_payload)
                $display("%0t: out_payload exp %h got %h", $time,
                         exp_r.out_payload, got.out_payload);
            if (got.queue_overflow !== exp_r.queue_overflow)
                $display("%0t: queue_overflow exp %b got %b", $time,
                         exp_r.queue_overflow, got.queue_overflow);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    ffb_cq_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    ffb_cq_pkg::out_t m_data;

    ffb_scoreboard sb = new();
    longint cycle_cnt = 0;
    bit     calm = 0;     // no idling on either side while set

    always #6 aclk = ~aclk;

    ffb_command_coalescing_queue i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, check every accepted transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
        end
    end

    // Send one step; valid stays up until accepted, gaps inserted at random.
    // Valid is left high after acceptance; the next gap or step takes it over.
    task automatic send_step(logic [1:0] md, logic [2:0] dv, logic [7:0] h, logic [47:0] p);
        ffb_cq_pkg::in_t t;
        t.mode = md;
        t.device = dv;
        t.report_head = h;
        t.report_payload = p;
        while (!calm && $urandom_range(99) < 29) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_step(t);
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Well-formed heads mostly: slot commands, stop-all, extended and odd heads.
    task automatic random_step(logic [2:0] dv);
        int r;
        logic [7:0] h;
        logic [47:0] p;
        logic [3:0] cmds[5] = '{ffb_cq_pkg::CMD_LOAD_PARAMS, ffb_cq_pkg::CMD_DL_PLAY,
                                ffb_cq_pkg::CMD_START, ffb_cq_pkg::CMD_HALT,
                                ffb_cq_pkg::CMD_REFRESH};
        r = $urandom_range(99);
        p = ($urandom_range(3) == 0) ? rnd48() : {40'h0, 8'($urandom_range(3))};
        if (r < 30) send_step(ffb_cq_pkg::MODE_FETCH, dv, 8'($urandom), rnd48());
        else if (r < 50) send_step(ffb_cq_pkg::MODE_ACK, dv, 8'($urandom), rnd48());
        else if (r < 53) send_step(MODE_UNUSED, dv, 8'($urandom), rnd48());
        else begin
            r = $urandom_range(99);
            if (r < 55) h = {4'($urandom_range(1, 15)), cmds[$urandom_range(4)]};
            else if (r < 62) h = {4'hF, ffb_cq_pkg::CMD_HALT};
            else if (r < 82) begin
                h = ffb_cq_pkg::HEAD_EXT;
                p[7:0] = 8'($urandom_range(0, 20));
            end else h = 8'($urandom);
            send_step(ffb_cq_pkg::MODE_ABSORB, dv, h, p);
        end
    endtask

    initial begin
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes, every mode, skipped codes, overflow, table full.
        calm = 1;
        send_step(ffb_cq_pkg::MODE_ACK, 3'd0, 8'h00, 48'h0);
        send_step(ffb_cq_pkg::MODE_FETCH, 3'd0, 8'hFF, '1);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, 8'h11, 48'hFFFF_FFFF_FFFF);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, 8'h11, 48'hFFFF_FFFF_FFFF);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, 8'hF2, 48'h0);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, 8'h10, 48'h1234_5678_9ABC);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, 8'hF3, 48'h0);
        send_step(ffb_cq_pkg::MODE_FETCH, 3'd7, 8'h00, 48'h0);
        send_step(ffb_cq_pkg::MODE_ACK, 3'd7, 8'h00, 48'h0);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, ffb_cq_pkg::HEAD_EXT,
                  {40'h0, ffb_cq_pkg::EXT_SKIP_A});
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, ffb_cq_pkg::HEAD_EXT,
                  {40'h0, ffb_cq_pkg::EXT_SKIP_E});
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, ffb_cq_pkg::HEAD_EXT, 48'hAA55_0000_0022);
        send_step(ffb_cq_pkg::MODE_ABSORB, 3'd7, 8'h3C, 48'h5);
        send_step(MODE_UNUSED, 3'd7, 8'hFF, '1);
        for (int i = 0; i < 18; i++)
            send_step(ffb_cq_pkg::MODE_ABSORB, 3'd5, 8'h07, 48'h0);   // fill queue past depth
        for (int i = 0; i < 18; i++)
            send_step(ffb_cq_pkg::MODE_ABSORB, 3'd6, ffb_cq_pkg::HEAD_EXT,
                      {40'h0, 8'(8'h20 + i)});
        for (int i = 0; i < 40; i++) begin
            send_step(ffb_cq_pkg::MODE_FETCH, 3'(5 + i % 3), 8'h00, 48'h0);
            send_step(ffb_cq_pkg::MODE_ACK, 3'(5 + i % 3), 8'h00, 48'h0);
        end

        // Random: random gaps around a stretch with no idling, few devices for depth.
        for (n = 0; n < 1220; n++) begin
            calm = (n >= 200 && n < 450);
            random_step(3'($urandom_range(0, (n % 300 < 150) ? 1 : 7)));
        end
        s_valid <= 0;
        calm = 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Ran %0d steps: %0d reports fetched, %0d overflows seen.",
                 sb.checked, sb.reports_seen, sb.overflows_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
